// ===== rtl/iba_pkg.sv =====
// Shared types and constants for the indexed block allocator.
// Used by iba_ctrl, iba_dpath and indexed_block_allocator_unit; no dependencies.
`default_nettype none

package iba_pkg;

  localparam int NUM_BLOCKS_DEF      = 64;
  localparam int RESERVED_BLOCKS_DEF = 10;
  localparam int INDEX_SLOTS_DEF     = 10;
  localparam int MAX_FILE_BLOCKS_DEF = 10;
  localparam int KEY_WIDTH_DEF       = 32;

  localparam int KEY_PORT_W  = 32;
  localparam int CNT_W       = 4;
  localparam int STATUS_W    = 3;
  localparam int OUT_SLOT_W  = 4;
  localparam int OUT_SEQ_W   = 4;
  localparam int OUT_BLOCK_W = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_TAKEN    = 3'd1,
    ST_BADSIZE  = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_NOSLOT   = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    init_step;
    logic    load_req;
    logic    slot_step;
    logic    blk_step;
    logic    commit_add;
    logic    free_step;
    logic    commit_del;
    logic    out_stat;
    logic    out_blk;
    status_e code;
  } iba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_done;
    logic slot_done;
    logic found;
    logic avail;
    logic op_del;
    logic bad_size;
    logic blk_last;
    logic blk_exhausted;
    logic free_done;
    logic out_free;
    logic emit_last;
  } iba_sts_t;

endpackage

`default_nettype wire

// ===== rtl/iba_ctrl.sv =====
// Request sequencer for the indexed block allocator.
// Depends on iba_pkg; drives iba_dpath through iba_cmd_t, reads iba_sts_t.
`default_nettype none

module iba_ctrl
  import iba_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  iba_sts_t sts_i,
  output iba_cmd_t cmd_o
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SLOT   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_BLK    = 4'd4;
  localparam logic [3:0] S_DFREE  = 4'd5;
  localparam logic [3:0] S_REPORT = 4'd6;
  localparam logic [3:0] S_ERD    = 4'd7;
  localparam logic [3:0] S_EWR    = 4'd8;

  logic [3:0] state_q, state_d;
  status_e    code_q, code_d;
  iba_cmd_t   cmd;

  always_comb begin
    state_d  = state_q;
    code_d   = code_q;
    cmd      = '0;
    cmd.code = code_q;
    case (state_q)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts_i.init_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_req = 1'b1;
          state_d      = S_SLOT;
        end
      end
      S_SLOT: begin
        cmd.slot_step = 1'b1;
        if (sts_i.slot_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.op_del) begin
          if (!sts_i.found) begin
            code_d  = ST_NOTFOUND;
            state_d = S_REPORT;
          end else begin
            state_d = S_DFREE;
          end
        end else if (sts_i.found) begin
          code_d  = ST_TAKEN;
          state_d = S_REPORT;
        end else if (sts_i.bad_size) begin
          code_d  = ST_BADSIZE;
          state_d = S_REPORT;
        end else begin
          state_d = S_BLK;
        end
      end
      S_BLK: begin
        cmd.blk_step = 1'b1;
        if (sts_i.blk_last) begin
          if (sts_i.avail) begin
            cmd.commit_add = 1'b1;
            state_d        = S_ERD;
          end else begin
            code_d  = ST_NOSLOT;
            state_d = S_REPORT;
          end
        end else if (sts_i.blk_exhausted) begin
          code_d  = ST_NOSPACE;
          state_d = S_REPORT;
        end
      end
      S_DFREE: begin
        cmd.free_step = 1'b1;
        if (sts_i.free_done) begin
          cmd.commit_del = 1'b1;
          code_d         = ST_OK;
          state_d        = S_REPORT;
        end
      end
      S_REPORT: begin
        if (sts_i.out_free) begin
          cmd.out_stat = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_ERD: begin
        state_d = S_EWR;
      end
      S_EWR: begin
        if (sts_i.out_free) begin
          cmd.out_blk = 1'b1;
          state_d     = sts_i.emit_last ? S_IDLE : S_ERD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/iba_dpath.sv =====
// Datapath of the indexed block allocator: block map, slot table, block lists,
// scan counters and result register. Depends on iba_pkg; steered by iba_ctrl.
`default_nettype none

module iba_dpath
  import iba_pkg::*;
#(
  parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF,
  parameter int INDEX_SLOTS     = INDEX_SLOTS_DEF,
  parameter int MAX_FILE_BLOCKS = MAX_FILE_BLOCKS_DEF,
  parameter int KEY_WIDTH       = KEY_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  iba_cmd_t               cmd_i,
  output iba_sts_t               sts_o,
  input  logic                   operation_i,
  input  logic [KEY_PORT_W-1:0]  file_key_i,
  input  logic [CNT_W-1:0]       block_count_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [OUT_SLOT_W-1:0]  index_slot_o,
  output logic [OUT_SEQ_W-1:0]   block_seq_o,
  output logic [OUT_BLOCK_W-1:0] block_number_o,
  output logic                   last_o
);

  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int SW = (INDEX_SLOTS > 1) ? $clog2(INDEX_SLOTS) : 1;
  localparam int FW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
  localparam int KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam int EW = KW + CNT_W;
  localparam int LW = SW + FW;
  localparam logic [BW-1:0] B_LAST = BW'(NUM_BLOCKS - 1);
  localparam logic [SW-1:0] S_LAST = SW'(INDEX_SLOTS - 1);
  localparam logic [BW-1:0] B_RES  = BW'(RESERVED_BLOCKS);
  localparam logic [5:0]    F_MAX  = 6'(MAX_FILE_BLOCKS);

  // memories
  logic          busy_mem [NUM_BLOCKS];
  logic [EW-1:0] slot_mem [INDEX_SLOTS];
  logic [BW-1:0] list_mem [2**LW];

  logic          busy_rd_q;
  logic [EW-1:0] slot_rd_q;
  logic [BW-1:0] list_rd_q;

  // request
  logic             op_q;
  logic [KW-1:0]    key_q;
  logic [CNT_W-1:0] size_q;

  // scan state
  logic [BW-1:0]    blk_ctr_q, blk_tag_q;
  logic             blk_rv_q;
  logic [SW-1:0]    slot_ctr_q, slot_tag_q;
  logic             slot_rv_q;
  logic             found_q, avail_q;
  logic [SW-1:0]    found_slot_q, free_slot_q;
  logic [CNT_W-1:0] found_size_q;
  logic [CNT_W-1:0] got_q, pos_q;
  logic             free_rv_q;
  logic [INDEX_SLOTS-1:0] slot_valid_q;

  // result register
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [OUT_SLOT_W-1:0]  out_slot_q;
  logic [OUT_SEQ_W-1:0]   out_seq_q;
  logic [OUT_BLOCK_W-1:0] out_block_q;
  logic                   out_last_q;

  logic          blk_hit, blk_last, blk_exh, out_free, emit_last, pos_lt;
  logic          slot_match, slot_free;
  logic [BW-1:0] blk_next;
  logic [SW-1:0] slot_next, sel_slot;
  logic          busy_we, busy_wd;
  logic [BW-1:0] busy_wa;
  logic          list_we;
  logic [LW-1:0] list_wa, list_ra;

  assign blk_next  = (blk_ctr_q == B_LAST) ? '0 : blk_ctr_q + 1'b1;
  assign slot_next = (slot_ctr_q == S_LAST) ? '0 : slot_ctr_q + 1'b1;

  assign blk_hit   = blk_rv_q && !busy_rd_q;
  assign blk_last  = blk_hit && ((got_q + 1'b1) == size_q);
  assign blk_exh   = blk_rv_q && (blk_tag_q == B_LAST) && !blk_last;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_last = ((pos_q + 1'b1) == size_q);
  assign pos_lt    = (pos_q < found_size_q);

  assign slot_match = slot_valid_q[slot_tag_q] && (slot_rd_q[KW-1:0] == key_q);
  assign slot_free  = !slot_valid_q[slot_tag_q];

  assign sel_slot = op_q ? found_slot_q : free_slot_q;
  assign list_ra  = {sel_slot, FW'(pos_q)};
  assign list_wa  = {free_slot_q, FW'(got_q)};
  assign list_we  = cmd_i.blk_step && blk_hit && avail_q;

  always_comb begin
    busy_we = 1'b0;
    busy_wa = list_rd_q;
    busy_wd = 1'b0;
    if (cmd_i.init_step) begin
      busy_we = 1'b1;
      busy_wa = blk_ctr_q;
      busy_wd = (blk_ctr_q < B_RES);
    end else if (cmd_i.free_step && free_rv_q) begin
      busy_we = 1'b1;
    end else if (cmd_i.out_blk) begin
      busy_we = 1'b1;
      busy_wd = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_we) busy_mem[busy_wa] <= busy_wd;
    busy_rd_q <= busy_mem[blk_ctr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_add) slot_mem[free_slot_q] <= {size_q, key_q};
    slot_rd_q <= slot_mem[slot_ctr_q];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[list_wa] <= blk_tag_q;
    list_rd_q <= list_mem[list_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= 1'b0;
      blk_ctr_q    <= '0;
      blk_rv_q     <= 1'b0;
      slot_ctr_q   <= '0;
      slot_rv_q    <= 1'b0;
      found_q      <= 1'b0;
      avail_q      <= 1'b0;
      got_q        <= '0;
      pos_q        <= '0;
      free_rv_q    <= 1'b0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.init_step) blk_ctr_q <= blk_next;
      if (cmd_i.load_req) begin
        op_q       <= operation_i;
        blk_ctr_q  <= '0;
        blk_rv_q   <= 1'b0;
        slot_ctr_q <= '0;
        slot_rv_q  <= 1'b0;
        found_q    <= 1'b0;
        avail_q    <= 1'b0;
        got_q      <= '0;
        pos_q      <= '0;
        free_rv_q  <= 1'b0;
      end
      if (cmd_i.slot_step) begin
        slot_ctr_q <= slot_next;
        slot_rv_q  <= 1'b1;
        if (slot_rv_q && slot_match && !found_q) found_q <= 1'b1;
        if (slot_rv_q && slot_free && !avail_q)  avail_q <= 1'b1;
      end
      if (cmd_i.blk_step) begin
        blk_ctr_q <= blk_next;
        blk_rv_q  <= 1'b1;
        if (blk_hit) got_q <= got_q + 1'b1;
      end
      if (cmd_i.free_step) begin
        free_rv_q <= pos_lt;
        if (pos_lt) pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.out_blk) pos_q <= pos_q + 1'b1;
      if (cmd_i.commit_add) slot_valid_q[free_slot_q] <= 1'b1;
      if (cmd_i.commit_del) slot_valid_q[found_slot_q] <= 1'b0;
      if (cmd_i.out_stat || cmd_i.out_blk) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      key_q  <= file_key_i[KW-1:0];
      size_q <= block_count_i;
    end
    if (cmd_i.slot_step) begin
      slot_tag_q <= slot_ctr_q;
      if (slot_rv_q && slot_match && !found_q) begin
        found_slot_q <= slot_tag_q;
        found_size_q <= slot_rd_q[EW-1:KW];
      end
      if (slot_rv_q && slot_free && !avail_q) free_slot_q <= slot_tag_q;
    end
    if (cmd_i.blk_step) blk_tag_q <= blk_ctr_q;
    if (cmd_i.out_stat) begin
      out_status_q <= cmd_i.code;
      out_slot_q   <= (cmd_i.code == ST_OK) ? OUT_SLOT_W'(found_slot_q) : '0;
      out_seq_q    <= '0;
      out_block_q  <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.out_blk) begin
      out_status_q <= ST_OK;
      out_slot_q   <= OUT_SLOT_W'(free_slot_q);
      out_seq_q    <= pos_q;
      out_block_q  <= OUT_BLOCK_W'(list_rd_q);
      out_last_q   <= emit_last;
    end
  end

  always_comb begin
    sts_o               = '0;
    sts_o.init_done     = (blk_ctr_q == B_LAST);
    sts_o.slot_done     = slot_rv_q && (slot_tag_q == S_LAST);
    sts_o.found         = found_q;
    sts_o.avail         = avail_q;
    sts_o.op_del        = op_q;
    sts_o.bad_size      = (size_q == '0) || ({2'b00, size_q} > F_MAX);
    sts_o.blk_last      = blk_last;
    sts_o.blk_exhausted = blk_exh;
    sts_o.free_done     = !pos_lt && !free_rv_q;
    sts_o.out_free      = out_free;
    sts_o.emit_last     = emit_last;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign index_slot_o   = out_slot_q;
  assign block_seq_o    = out_seq_q;
  assign block_number_o = out_block_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/indexed_block_allocator_unit.sv =====
// Add request: load, slot-table scan, decision, block-map scan, then one result per
//   allocated block; failures end in a single status result instead.
// Delete request: load, slot-table scan, decision, freeing of the file's blocks, status result.
// One request at a time; the block-map scan dominates (one flag per cycle).
// After reset an init pass writes every block-map flag, marking the reserved blocks busy; no request is taken.
// Depends on iba_pkg, iba_ctrl and iba_dpath.
`default_nettype none

module indexed_block_allocator_unit
  import iba_pkg::*;
#(
  parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF,
  parameter int INDEX_SLOTS     = INDEX_SLOTS_DEF,
  parameter int MAX_FILE_BLOCKS = MAX_FILE_BLOCKS_DEF,
  parameter int KEY_WIDTH       = KEY_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic [KEY_PORT_W-1:0]  file_key_i,
  input  logic [CNT_W-1:0]       block_count_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [OUT_SLOT_W-1:0]  index_slot_o,
  output logic [OUT_SEQ_W-1:0]   block_seq_o,
  output logic [OUT_BLOCK_W-1:0] block_number_o,
  output logic                   last_o
);

  iba_cmd_t cmd;
  iba_sts_t sts;

  iba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iba_dpath #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .RESERVED_BLOCKS (RESERVED_BLOCKS),
    .INDEX_SLOTS     (INDEX_SLOTS),
    .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS),
    .KEY_WIDTH       (KEY_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .file_key_i     (file_key_i),
    .block_count_i  (block_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .index_slot_o   (index_slot_o),
    .block_seq_o    (block_seq_o),
    .block_number_o (block_number_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
